// ----- hdl/tpzc_pkg.sv -----
`default_nettype none
package tpzc_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 32;
  localparam int COEF_FRAC_BITS = 24;

  // A product is exact in the sum of both operand widths.
  localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
  // Five products plus the rounding constant need three more bits.
  localparam int ACC_W  = PROD_W + 3;
  // The width of the sum after the fractional bits are dropped.
  localparam int RES_W  = ACC_W - COEF_FRAC_BITS;

  // Configuration register index width and data width.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_WIDTH;

  // Half an output LSB, added before the fractional bits are dropped.
  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  // Limits after reset: the full range of a sample.
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_B0 = 3'd0,
    CFG_COEF_B1 = 3'd1,
    CFG_COEF_B2 = 3'd2,
    CFG_COEF_A1 = 3'd3,
    CFG_COEF_A2 = 3'd4,
    CFG_OUT_MIN = 3'd5,
    CFG_OUT_MAX = 3'd6
  } cfg_idx_t;

  // Coefficients and limits as seen by the datapath.
  typedef struct packed {
    coef_t   b0;
    coef_t   b1;
    coef_t   b2;
    coef_t   a1;
    coef_t   a2;
    sample_t out_min;
    sample_t out_max;
  } cfg_set_t;

  // Sample history of the filter.
  typedef struct packed {
    sample_t e1;
    sample_t e2;
    sample_t y1;
    sample_t y2;
  } hist_t;

endpackage
`default_nettype wire

// ----- hdl/tpzc_cfg_regs.sv -----
`default_nettype none
module tpzc_cfg_regs
  import tpzc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_set_t                   cfg
);

  cfg_set_t cfg_r;
  cfg_set_t cfg_nxt;

  // Decode the write; an index beyond the map leaves every register alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_COEF_B0: cfg_nxt.b0      = coef_t'(wr_data);
        CFG_COEF_B1: cfg_nxt.b1      = coef_t'(wr_data);
        CFG_COEF_B2: cfg_nxt.b2      = coef_t'(wr_data);
        CFG_COEF_A1: cfg_nxt.a1      = coef_t'(wr_data);
        CFG_COEF_A2: cfg_nxt.a2      = coef_t'(wr_data);
        CFG_OUT_MIN: cfg_nxt.out_min = wr_data[SAMPLE_WIDTH-1:0];
        CFG_OUT_MAX: cfg_nxt.out_max = wr_data[SAMPLE_WIDTH-1:0];
        default:     cfg_nxt         = cfg_r;
      endcase
    end
  end

  // Coefficients clear to zero, limits open to the full sample range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0      <= '0;
      cfg_r.b1      <= '0;
      cfg_r.b2      <= '0;
      cfg_r.a1      <= '0;
      cfg_r.a2      <= '0;
      cfg_r.out_min <= SAMPLE_MIN;
      cfg_r.out_max <= SAMPLE_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- hdl/tpzc_datapath.sv -----
`default_nettype none
module tpzc_datapath
  import tpzc_pkg::*;
(
  input  wire cfg_set_t   cfg,
  input  wire hist_t      hist,
  input  wire sample_t    e0,
  output sample_t    drive,
  output logic       clamped
);

  logic signed [PROD_W-1:0] p_b0;
  logic signed [PROD_W-1:0] p_b1;
  logic signed [PROD_W-1:0] p_b2;
  logic signed [PROD_W-1:0] p_a1;
  logic signed [PROD_W-1:0] p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RES_W-1:0]  res;
  logic signed [RES_W-1:0]  lim_hi;
  logic signed [RES_W-1:0]  lim_lo;
  logic signed [RES_W-1:0]  v_hi;
  logic signed [RES_W-1:0]  v_lo;
  logic                     hit_hi;
  logic                     hit_lo;

  // Five exact products in parallel.
  assign p_b0 = cfg.b0 * e0;
  assign p_b1 = cfg.b1 * hist.e1;
  assign p_b2 = cfg.b2 * hist.e2;
  assign p_a1 = cfg.a1 * hist.y1;
  assign p_a2 = cfg.a2 * hist.y2;

  // Full-width sum with half an LSB added, so that the truncation rounds to nearest.
  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2) + RND_HALF;

  // Dropping the fractional bits is an arithmetic shift.
  assign res = acc[ACC_W-1:COEF_FRAC_BITS];

  // Limits widened to the rounded sum.
  assign lim_hi = RES_W'(cfg.out_max);
  assign lim_lo = RES_W'(cfg.out_min);

  // Upper limit is tested first and the lower limit last, so the lower one
  // wins when the limits are crossed.
  assign hit_hi = (res >= lim_hi);
  assign v_hi   = hit_hi ? lim_hi : res;
  assign hit_lo = (v_hi <= lim_lo);
  assign v_lo   = hit_lo ? lim_lo : v_hi;

  assign drive   = v_lo[SAMPLE_WIDTH-1:0];
  assign clamped = hit_hi | hit_lo;

endmodule
`default_nettype wire

// ----- hdl/two_pole_two_zero_compensator_unit.sv -----
// The result for e0_r is registered in drive_r when the input stage hands it
// on. Throughput: one word per cycle while out_stall is low; each output is
// fed back to the next word through the output history in the single compute
// stage. Reset (rst_n low, synchronous): coefficients and history clear to
// zero, limits open to the full sample range, and both pipeline stages empty.
`default_nettype none
module two_pole_two_zero_compensator_unit
  import tpzc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // error samples in
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_WIDTH-1:0] in_error_sample,
  // drive values out
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SAMPLE_WIDTH-1:0]    out_drive_value,
  output logic                       out_was_clamped,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_set_t cfg;
  hist_t    hist_r;
  hist_t    hist_nxt;
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  sample_t  e0_r;
  logic     res_valid_r;
  logic     res_valid_nxt;
  sample_t  drive_r;
  logic     clamped_r;
  sample_t  drive_c;
  logic     clamped_c;
  logic     in_take;
  logic     s1_move;

  // Configuration registers take every write at once.
  assign cfg_ready = 1'b1;

  tpzc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tpzc_datapath u_dp (
    .cfg     (cfg),
    .hist    (hist_r),
    .e0      (e0_r),
    .drive   (drive_c),
    .clamped (clamped_c)
  );

  // The input stage hands its word on when the result register is free or
  // being emptied; it takes a new word when it is empty or handing on.
  assign s1_move  = s1_valid_r & (~res_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_move;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt  = in_take | (s1_valid_r & ~s1_move);
    res_valid_nxt = s1_move | (res_valid_r & out_stall);
  end

  // History shifts only when a word's result is registered.
  always_comb begin
    hist_nxt = hist_r;
    if (s1_move) begin
      hist_nxt.e2 = hist_r.e1;
      hist_nxt.e1 = e0_r;
      hist_nxt.y2 = hist_r.y1;
      hist_nxt.y1 = drive_c;
    end
  end

  // Control state and history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      hist_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      res_valid_r <= res_valid_nxt;
      hist_r      <= hist_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      e0_r <= sample_t'(in_error_sample);
    end
    if (s1_move) begin
      drive_r   <= drive_c;
      clamped_r <= clamped_c;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_drive_value = drive_r;
  assign out_was_clamped = clamped_r;

endmodule
`default_nettype wire
